[sv/kcl_pkg.sv]
// kcl_pkg: shared types, constants and helper functions for the keypad code lock.
// Used by every module of the block; depends on nothing.
`default_nettype none
package kcl_pkg;

   // number of digits in one code entry
   localparam int CODE_LENGTH = 4;
   // digit position counter width
   localparam int POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   // output buffer depth and its count width
   localparam int BUF_DEPTH = 4;
   localparam int BUF_AW = $clog2(BUF_DEPTH);
   localparam int BUF_CW = BUF_AW + 1;

   // key coordinates
   localparam logic [1:0] BLANK_ROW = 2'd3;
   localparam logic [1:0] ZERO_COL = 2'd1;
   localparam logic [1:0] NO_KEY_COL = 2'd3;

   // reset value of the secret code register
   localparam logic [15:0] SECRET_RESET = 16'h1234;

   typedef enum logic [2:0] {
      ST_TAKEN    = 3'd0,
      ST_ENTERED  = 3'd1,
      ST_MISMATCH = 3'd2,
      ST_GRANTED  = 3'd3,
      ST_DENIED   = 3'd4
   } status_type;

   // one result; packed so that status lands in the low bits
   typedef struct packed {
      logic [1:0] position;
      status_type status;
   } result_type;

   typedef logic [3:0] digit_type;

   // digit for rows 0..2: 3*row + column + 1
   function automatic digit_type key_digit(input logic [1:0] row, input logic [1:0] col);
      digit_type r4;
      r4 = {2'b00, row};
      return r4 + r4 + r4 + {2'b00, col} + 4'd1;
   endfunction

   // digit e of the secret code, first digit in the top nibble; zero past four
   function automatic digit_type secret_digit(input logic [15:0] code, input int e);
      digit_type d;
      d = 4'd0;
      if (e < 4) begin
         d = code[4*(3-e) +: 4];
      end
      return d;
   endfunction

endpackage
`default_nettype wire

[sv/kcl_lock_core.sv]
// kcl_lock_core: input register, digit entry/confirm state and result decision.
// Depends on kcl_pkg.
`default_nettype none
module kcl_lock_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [1:0]          key_row,
   input  wire logic [1:0]          key_column,
   input  wire logic [15:0]         secret_code,
   output logic                     busy,
   output logic                     push,
   output kcl_pkg::result_type      result
);

   logic                        valid_ff;
   logic [1:0]                  row_ff;
   logic [1:0]                  col_ff;
   logic                        confirm_ff, confirm_in;
   logic [kcl_pkg::POS_W-1:0]   pos_ff, pos_in;
   kcl_pkg::digit_type          work_ff [kcl_pkg::CODE_LENGTH];
   kcl_pkg::digit_type          work_in [kcl_pkg::CODE_LENGTH];
   kcl_pkg::digit_type          saved_ff [kcl_pkg::CODE_LENGTH];
   kcl_pkg::digit_type          saved_in [kcl_pkg::CODE_LENGTH];
   logic                        key_live;
   logic                        last_pos;
   logic                        same;
   logic                        right;
   kcl_pkg::status_type         status;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         row_ff <= key_row;
         col_ff <= key_column;
      end
   end

   assign busy = valid_ff;
   // column 3 means no key: no result and no state change
   assign key_live = valid_ff && (col_ff != kcl_pkg::NO_KEY_COL);
   assign last_pos = (pos_ff == kcl_pkg::POS_W'(kcl_pkg::CODE_LENGTH - 1));

   // per-press update and decision
   always_comb begin
      confirm_in = confirm_ff;
      pos_in     = pos_ff;
      status     = kcl_pkg::ST_TAKEN;
      same       = 1'b1;
      right      = 1'b1;
      for (int e = 0; e < kcl_pkg::CODE_LENGTH; e++) begin
         work_in[e]  = work_ff[e];
         saved_in[e] = saved_ff[e];
      end

      // blank keys in row 3 leave the stored digit alone
      if (row_ff != kcl_pkg::BLANK_ROW) begin
         work_in[pos_ff] = kcl_pkg::key_digit(row_ff, col_ff);
      end else if (col_ff == kcl_pkg::ZERO_COL) begin
         work_in[pos_ff] = 4'd0;
      end

      for (int e = 0; e < kcl_pkg::CODE_LENGTH; e++) begin
         if (saved_ff[e] != work_in[e]) begin
            same = 1'b0;
         end
         if (saved_ff[e] != kcl_pkg::secret_digit(secret_code, e)) begin
            right = 1'b0;
         end
      end

      if (!last_pos) begin
         pos_in = pos_ff + 1'b1;
      end else begin
         pos_in = '0;
         if (!confirm_ff) begin
            for (int e = 0; e < kcl_pkg::CODE_LENGTH; e++) begin
               saved_in[e] = work_in[e];
            end
            confirm_in = 1'b1;
            status     = kcl_pkg::ST_ENTERED;
         end else begin
            confirm_in = 1'b0;
            if (!same) begin
               status = kcl_pkg::ST_MISMATCH;
            end else if (right) begin
               status = kcl_pkg::ST_GRANTED;
            end else begin
               status = kcl_pkg::ST_DENIED;
            end
         end
      end
   end

   // lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_ff <= 1'b0;
         pos_ff     <= '0;
         for (int e = 0; e < kcl_pkg::CODE_LENGTH; e++) begin
            work_ff[e]  <= 4'd0;
            saved_ff[e] <= 4'd0;
         end
      end else if (key_live) begin
         confirm_ff <= confirm_in;
         pos_ff     <= pos_in;
         for (int e = 0; e < kcl_pkg::CODE_LENGTH; e++) begin
            work_ff[e]  <= work_in[e];
            saved_ff[e] <= saved_in[e];
         end
      end
   end

   assign push            = key_live;
   assign result.status   = status;
   assign result.position = 2'(pos_ff);

endmodule
`default_nettype wire

[sv/kcl_out_buf.sv]
// kcl_out_buf: small result queue that decouples the lock logic from a stalling receiver.
// Depends on kcl_pkg.
`default_nettype none
module kcl_out_buf (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire kcl_pkg::result_type        push_data,
   input  wire logic                       pop,
   output logic                            not_empty,
   output kcl_pkg::result_type             head,
   output logic [kcl_pkg::BUF_CW-1:0]      count
);

   kcl_pkg::result_type               mem_ff [kcl_pkg::BUF_DEPTH];
   logic [kcl_pkg::BUF_AW-1:0]        wr_ptr_ff;
   logic [kcl_pkg::BUF_AW-1:0]        rd_ptr_ff;
   logic [kcl_pkg::BUF_CW-1:0]        count_ff;
   logic                              do_pop;

   assign do_pop = pop && (count_ff != '0);

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
`default_nettype wire

[sv/keypad_code_lock.sv]
// keypad_code_lock: top level of the keypad code lock.
// Depends on kcl_pkg, kcl_lock_core and kcl_out_buf.
//
// Usage:
//   req_* carries one key press per request: tdata[1:0] row, tdata[3:2] column.
//   A column of 3 means no key; such a request is taken but yields no result.
//   rsp_* carries one result per real key press: tdata[2:0] status
//   (taken, entered, mismatch, granted, denied), tdata[4:3] filled position.
//   csr_wr_en/csr_wr_data write the four BCD digits of the secret code;
//   write only while no request is in flight.
// Path: an accepted request passes the input register, then the lock logic
//   into the result queue; rsp_tvalid rises once a result is queued.
// Throughput: one request per cycle while the result queue has room, set by
//   the combinational lock logic between the input register and the queue.
// Stall: a four-entry result queue absorbs results while rsp_tready is low;
//   req_tready drops once queue entries plus the request in flight fill it.
// Reset: synchronous; clears the entry state, the digit stores, the queue,
//   and sets the secret code to 1234. req_tready is low during reset.
`default_nettype none
module keypad_code_lock (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [1:0] key_row, [3:2] key_column
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [2:0] status, [4:3] position
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [15:0]                   secret_ff;
   logic                          accept;
   logic                          busy;
   logic                          push;
   kcl_pkg::result_type           result;
   kcl_pkg::result_type           head;
   logic [kcl_pkg::BUF_CW-1:0]    count;
   logic [kcl_pkg::BUF_CW:0]      occupied;

   // secret code register
   always_ff @(posedge clock) begin
      if (reset) begin
         secret_ff <= kcl_pkg::SECRET_RESET;
      end else if (csr_wr_en) begin
         secret_ff <= csr_wr_data;
      end
   end

   // room for one more request counting the one in flight
   assign occupied   = {1'b0, count} + {{kcl_pkg::BUF_CW{1'b0}}, busy};
   assign req_tready = !reset && (occupied < (kcl_pkg::BUF_CW+1)'(kcl_pkg::BUF_DEPTH));
   assign accept     = req_tvalid && req_tready;

   kcl_lock_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .key_row     (req_tdata[1:0]),
      .key_column  (req_tdata[3:2]),
      .secret_code (secret_ff),
      .busy        (busy),
      .push        (push),
      .result      (result)
   );

   kcl_out_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop       (rsp_tready),
      .not_empty (rsp_tvalid),
      .head      (head),
      .count     (count)
   );

   assign rsp_tdata = {3'b000, head};

endmodule
`default_nettype wire

[sv/kcl_checker.sv]
// kcl_checker: port-level assertions for keypad_code_lock, bound to the top level.
// Depends on kcl_pkg.
`default_nettype none
module kcl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // status is one of the five defined codes
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= 3'(kcl_pkg::ST_DENIED)))
      else $error("illegal status code");

   // every status other than taken comes from the final position
   a_final_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != 3'(kcl_pkg::ST_TAKEN))
      |-> (rsp_tdata[4:3] == 2'(kcl_pkg::CODE_LENGTH - 1)))
      else $error("phase end reported at wrong position");

   // no result appears without an accepted request ahead of it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) && !$past(req_tvalid && req_tready)
      |=> !rsp_tvalid)
      else $error("result without a request");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

[tb/keypad_code_lock_checker.sv]
`timescale 1ns / 1ps
// keypad_code_lock_checker: watches the request, response and CSR ports of the
// keypad code lock, predicts every response and compares it field by field.
// Depends on kcl_pkg for the code length, key constants, status codes and result layout.
module keypad_code_lock_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [1:0] key_row, [3:2] key_column
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,    // [2:0] status, [4:3] position
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   output int               mismatch_count,
   output int               outstanding
);

   // lock state as the predictor sees it
   logic [15:0] secret_code_q;
   logic        in_confirm;
   int          fill_pos;
   logic [3:0]  keyed_digits[kcl_pkg::CODE_LENGTH];
   logic [3:0]  entered_digits[kcl_pkg::CODE_LENGTH];

   // responses still owed by the lock, oldest first
   kcl_pkg::result_type awaited_results[$];

   // print one line and count
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t lock check: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // apply one key press to the lock state and queue the response it owes
   task automatic predict_key_press(input logic [1:0] row, input logic [1:0] col);
      int                  pos;
      logic                same_code;
      logic                right_code;
      logic [3:0]          code_digit;
      kcl_pkg::status_type verdict;
      kcl_pkg::result_type res;
      // column 3: nothing pressed, no response and no state change
      if (col != kcl_pkg::NO_KEY_COL) begin
         pos = fill_pos;
         verdict = kcl_pkg::ST_TAKEN;
         if (pos >= kcl_pkg::CODE_LENGTH) begin
            pos = 0;
         end
         // blank keys keep whatever digit sat at this position
         if (row != kcl_pkg::BLANK_ROW) begin
            keyed_digits[pos] = 4'(3 * int'(row) + int'(col) + 1);
         end else if (col == kcl_pkg::ZERO_COL) begin
            keyed_digits[pos] = 4'd0;
         end
         if (pos + 1 < kcl_pkg::CODE_LENGTH) begin
            fill_pos = pos + 1;
         end else begin
            fill_pos = 0;
            if (!in_confirm) begin
               entered_digits = keyed_digits;
               in_confirm = 1'b1;
               verdict = kcl_pkg::ST_ENTERED;
            end else begin
               same_code = 1'b1;
               right_code = 1'b1;
               for (int e = 0; e < kcl_pkg::CODE_LENGTH; e++) begin
                  // positions past four compare against zero
                  code_digit = (e < 4) ? 4'(secret_code_q >> (4 * (3 - e))) : 4'd0;
                  if (entered_digits[e] != keyed_digits[e]) same_code = 1'b0;
                  if (entered_digits[e] != code_digit) right_code = 1'b0;
               end
               in_confirm = 1'b0;
               if (!same_code) verdict = kcl_pkg::ST_MISMATCH;
               else verdict = right_code ? kcl_pkg::ST_GRANTED : kcl_pkg::ST_DENIED;
            end
         end
         res.status = verdict;
         res.position = 2'(pos);
         awaited_results.push_back(res);
      end
   endtask

   // everything is sampled at the rising edge; stimulus moves on the falling one
   always @(posedge clock) begin : watch_ports
      kcl_pkg::result_type got;
      kcl_pkg::result_type want;
      if (reset) begin
         mismatch_count = 0;
         secret_code_q = kcl_pkg::SECRET_RESET;
         in_confirm = 1'b0;
         fill_pos = 0;
         for (int e = 0; e < kcl_pkg::CODE_LENGTH; e++) begin
            keyed_digits[e] = 4'd0;
            entered_digits[e] = 4'd0;
         end
         awaited_results.delete();
      end else begin
         // response side first: a request never answers in its own cycle
         if (rsp_tvalid && rsp_tready) begin
            got = kcl_pkg::result_type'(rsp_tdata[4:0]);
            if (awaited_results.size() == 0) begin
               report_mismatch("response with none outstanding, tdata", rsp_tdata, -1);
            end else begin
               want = awaited_results.pop_front();
               if (got.status != want.status) begin
                  report_mismatch("status", got.status, want.status);
               end
               if (got.position != want.position) begin
                  report_mismatch("position", got.position, want.position);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_key_press(req_tdata[1:0], req_tdata[3:2]);
         end
         if (csr_wr_en) begin
            secret_code_q = csr_wr_data;
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

[tb/keypad_code_lock_tb.sv]
`timescale 1ns / 1ps
// keypad_code_lock_tb: drives key presses and secret code writes into the keypad
// code lock and gives the verdict. Depends on kcl_pkg, the lock RTL and the checker.
module keypad_code_lock_tb;

   localparam int HOLD_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;     // [1:0] key_row, [3:2] key_column
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [2:0] status, [4:3] position
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   int          mismatch_count;
   int          outstanding;

   // shared stimulus controls
   bit          idling_on = 1'b0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          real_keys = 0;
   logic [15:0] lock_code = kcl_pkg::SECRET_RESET;

   keypad_code_lock i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   keypad_code_lock_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: random stalls, plus one long hold-off counted here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = !(idling_on && $urandom_range(99) < 17);
      end
   end

   // offer one request and wait for its handshake; returns at a falling edge
   task automatic press_key(input logic [1:0] row, input logic [1:0] col);
      while (idling_on && $urandom_range(99) < 17) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {4'b0000, col, row};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (col != kcl_pkg::NO_KEY_COL) real_keys++;
   endtask

   task automatic press_digit(input int d);
      if (d == 0) press_key(kcl_pkg::BLANK_ROW, kcl_pkg::ZERO_COL);
      else press_key(2'((d - 1) / 3), 2'((d - 1) % 3));
   endtask

   task automatic press_blank();
      press_key(kcl_pkg::BLANK_ROW, ($urandom_range(1) != 0) ? 2'd2 : 2'd0);
   endtask

   task automatic press_stray_key();
      press_key(2'($urandom_range(3)), 2'($urandom_range(2)));
   endtask

   // wait for the lock to drain, then load a new secret code
   task automatic write_lock_code(input logic [15:0] code);
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      // no-key requests may still be in the pipe
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = code;
      @(negedge clock);
      csr_wr_en = 1'b0;
      lock_code = code;
   endtask

   // one entry plus confirm attempt, often the right code, sometimes mistyped
   task automatic try_code();
      int         digits[4];
      int         idx;
      logic [3:0] nib;
      for (int i = 0; i < 4; i++) begin
         nib = lock_code[4 * (3 - i) +: 4];
         if ($urandom_range(2) != 0 && nib <= 4'd9) digits[i] = nib;
         else digits[i] = $urandom_range(9);
      end
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1 && $urandom_range(3) == 0) begin
            idx = $urandom_range(3);
            digits[idx] = (digits[idx] + 1 + $urandom_range(8)) % 10;
         end
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(99) < 8) press_blank();
            else press_digit(digits[i]);
            if ($urandom_range(99) < 3) press_key(2'($urandom_range(3)), kcl_pkg::NO_KEY_COL);
         end
      end
   endtask

   // mostly aligned attempts, with no-key noise and stray presses mixed in
   task automatic random_phase(input int key_total);
      int start;
      int r;
      start = real_keys;
      while (real_keys - start < key_total) begin
         r = $urandom_range(99);
         if (r < 4) begin
            press_key(2'($urandom_range(3)), kcl_pkg::NO_KEY_COL);
         end else if (r < 10) begin
            press_stray_key();
         end else begin
            // every attempt is eight real keys; realign after strays
            while (real_keys % 8 != 0) press_stray_key();
            try_code();
         end
      end
   endtask

   // main stimulus
   initial begin
      logic [15:0] code;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // directed: right code with reset secret -> granted
      press_digit(1); press_digit(2); press_digit(3); press_digit(4);
      press_digit(1); press_digit(2); press_digit(3); press_digit(4);
      // no key pressed
      press_key(2'd0, kcl_pkg::NO_KEY_COL);
      press_key(kcl_pkg::BLANK_ROW, kcl_pkg::NO_KEY_COL);
      // zero, nine and both blank keys, confirmed alike -> denied
      press_digit(0); press_digit(9);
      press_key(kcl_pkg::BLANK_ROW, 2'd0); press_key(kcl_pkg::BLANK_ROW, 2'd2);
      press_digit(0); press_digit(9);
      press_key(kcl_pkg::BLANK_ROW, 2'd0); press_key(kcl_pkg::BLANK_ROW, 2'd2);
      // confirm differs in the last digit -> mismatch
      press_digit(7); press_digit(8); press_digit(5); press_digit(6);
      press_digit(7); press_digit(8); press_digit(5); press_digit(5);

      // random phases over several secret codes, extremes first
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: code = 16'h0000;
            1: code = 16'h9999;
            2: code = 16'hFFFF;
            4: code = 16'($urandom);
            default: code = {4'($urandom_range(9)), 4'($urandom_range(9)),
                             4'($urandom_range(9)), 4'($urandom_range(9))};
         endcase
         write_lock_code(code);
         // first phase runs without any idling
         idling_on = (p != 0);
         if (p == 1) hold_request = 1'b1;
         random_phase(300);
      end

      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

[keypad_code_lock.f]
sv/kcl_pkg.sv
sv/kcl_lock_core.sv
sv/kcl_out_buf.sv
sv/keypad_code_lock.sv
sv/kcl_checker.sv
tb/keypad_code_lock_checker.sv
tb/keypad_code_lock_tb.sv
